// File: rtl/lnu_pkg.sv
// Package for the layer normalization unit: controller state type, command and
// status structs, and fixed widths. No dependencies.
`timescale 1ns / 1ps
package lnu_pkg;

  localparam int SampleW = 16;
  localparam int LenW    = 11;
  localparam int EpsW    = 16;
  localparam int MeanW   = 32;
  localparam int InvW    = 24;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncRead = 1'b1;

  localparam logic CfgLength  = 1'b0;
  localparam logic CfgEpsilon = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_RD_MUL1,
    ST_RD_MUL2,
    ST_RD_OUT,
    ST_SUM,
    ST_MEAN,
    ST_VAR,
    ST_VAR_DIV,
    ST_RECIP,
    ST_SQRT,
    ST_DONE
  } lnu_state_t;

  typedef struct packed {
    logic load_write;   // write the three stores at the input index
    logic rd_fetch;     // issue store read for a read item
    logic rd_mul1;      // latch d = x - mean, gain and offset
    logic rd_mul2;      // latch t = d * inverse_deviation
    logic rd_out;       // latch u = t * gain for the result
    logic stat_clear;   // clear accumulators and counters
    logic sum_step;     // one element of the mean pass
    logic mean_start;   // start the mean division
    logic var_step;     // one element of the variance pass
    logic var_start;    // start the variance division
    logic recip_start;  // start 2^48 / v
    logic sqrt_start;   // start the square root
    logic commit;       // latch new statistics
  } lnu_cmd_t;

  typedef struct packed {
    logic pass_done;  // the pass counter reached the length
    logic unit_busy;  // divider or root unit still iterating
  } lnu_sts_t;

endpackage

// File: rtl/layer_normalization_unit.sv
// Top level of the layer normalization unit: configuration registers, the
// controller and the datapath. Depends on lnu_pkg, lnu_ctrl and lnu_datapath.
`timescale 1ns / 1ps
// Usage:
// An item is transferred when start is high and busy is low. A load item
// (in_func = 0) writes sample, gain and offset at in_index. When the load
// lands at index L-1, the unit runs a mean pass, a divide, a variance pass,
// two more divides and a square root, keeping busy high until they finish;
// their lengths are set by the single store read port and the bit-serial
// divider and root unit.
// A read item (in_func = 1) returns out_normalized with the out_valid strobe
// after its read, multiply and output states; busy stays high until then; the
// receiver cannot stall, so the result must be captured in that cycle.
// Configuration registers (length in use, epsilon) are written through the
// cfg_ channel; the user must do so only while the unit is idle, and the
// block does not enforce it; cfg_ready is always high. Reset sets mean 0,
// inverse deviation 1.0, length 1024, epsilon 1; the stores are not cleared.
module layer_normalization_unit #(
  parameter int MAX_LEN = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [9:0]         in_index,
  input  logic signed [15:0] in_sample,
  input  logic signed [15:0] in_gain,
  input  logic signed [15:0] in_offset,
  output logic               out_valid,
  output logic signed [15:0] out_normalized,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import lnu_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);

  logic [LenW-1:0] len_r;
  logic [EpsW-1:0] eps_r;
  logic [CW-1:0]   eff_len;
  logic            last;
  logic            range_ok;
  lnu_cmd_t        cmd;
  lnu_sts_t        sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LenW'(1024);
      eps_r <= EpsW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgLength:  len_r <= cfg_data[LenW-1:0];
        CfgEpsilon: eps_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The effective length is clamped to 1..MAX_LEN.
  always_comb begin
    if (len_r == '0) eff_len = CW'(1);
    else if (32'(len_r) > MAX_LEN) eff_len = CW'(MAX_LEN);
    else eff_len = CW'(len_r);
  end

  assign last = (32'(in_index) == 32'(eff_len) - 1);

  lnu_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .func_i (in_func),
    .last_i (last),
    .range_i(range_ok),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  lnu_datapath #(.MaxLen(MAX_LEN)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_index      (in_index),
    .in_sample     (in_sample),
    .in_gain       (in_gain),
    .in_offset     (in_offset),
    .len_i         (eff_len),
    .eps_i         (eps_r),
    .range_o       (range_ok),
    .out_valid     (out_valid),
    .out_normalized(out_normalized)
  );

endmodule

// File: rtl/lnu_ctrl.sv
// Controller state machine of the layer normalization unit.
// Depends on lnu_pkg.
`timescale 1ns / 1ps
module lnu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              func_i,
  input  logic              last_i,   // load hits index L-1
  input  logic              range_i,  // index within MAX_LEN
  input  lnu_pkg::lnu_sts_t sts_i,
  output lnu_pkg::lnu_cmd_t cmd_o,
  output logic              busy
);
  import lnu_pkg::*;

  lnu_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (func_i == FuncLoad) begin
            cmd_o.load_write = range_i;
            if (range_i && last_i) begin
              cmd_o.stat_clear = 1'b1;
              state_nxt = ST_SUM;
            end
          end else begin
            cmd_o.rd_fetch = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: state_nxt = ST_RD_MUL1;
      ST_RD_MUL1: begin
        cmd_o.rd_mul1 = 1'b1;
        state_nxt = ST_RD_MUL2;
      end
      ST_RD_MUL2: begin
        cmd_o.rd_mul2 = 1'b1;
        state_nxt = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        cmd_o.rd_out = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SUM: begin
        if (sts_i.pass_done) begin
          cmd_o.mean_start = 1'b1;
          state_nxt = ST_MEAN;
        end else begin
          cmd_o.sum_step = 1'b1;
        end
      end
      ST_MEAN: begin
        if (!sts_i.unit_busy) begin
          cmd_o.stat_clear = 1'b1;
          state_nxt = ST_VAR;
        end
      end
      ST_VAR: begin
        if (sts_i.pass_done) begin
          cmd_o.var_start = 1'b1;
          state_nxt = ST_VAR_DIV;
        end else begin
          cmd_o.var_step = 1'b1;
        end
      end
      ST_VAR_DIV: begin
        if (!sts_i.unit_busy) begin
          cmd_o.recip_start = 1'b1;
          state_nxt = ST_RECIP;
        end
      end
      ST_RECIP: begin
        if (!sts_i.unit_busy) begin
          cmd_o.sqrt_start = 1'b1;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (!sts_i.unit_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd_o.commit = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/lnu_datapath.sv
// Datapath of the layer normalization unit: element stores, statistics passes,
// a shared restoring divider, a bit-serial square root and the read pipeline.
// Depends on lnu_pkg.
`timescale 1ns / 1ps
module lnu_datapath #(
  parameter int MaxLen = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lnu_pkg::lnu_cmd_t         cmd_i,
  output lnu_pkg::lnu_sts_t         sts_o,
  input  logic [9:0]                in_index,
  input  logic signed [15:0]        in_sample,
  input  logic signed [15:0]        in_gain,
  input  logic signed [15:0]        in_offset,
  input  logic [$clog2(MaxLen+1)-1:0] len_i,
  input  logic [15:0]               eps_i,
  output logic                      range_o,
  output logic                      out_valid,
  output logic signed [15:0]        out_normalized
);
  import lnu_pkg::*;

  localparam int AW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int CW = $clog2(MaxLen + 1);
  localparam int SumW = 16 + CW + 1;
  localparam int SqW  = 64;
  localparam int DivW = 64;
  localparam int DcW  = 7;

  logic signed [15:0] sample_mem [MaxLen];
  logic signed [15:0] gain_mem   [MaxLen];
  logic signed [15:0] offset_mem [MaxLen];

  logic [CW-1:0] cnt_r;
  logic          rvalid_r;
  logic [AW-1:0] waddr, raddr;
  logic          in_range;
  logic signed [15:0] x_q, g_q, o_q;
  logic          issue;

  // Extended index is compared against MaxLen so any depth works.
  assign in_range = ({{(CW>10?CW-10:0){1'b0}}, in_index} < CW'(MaxLen));
  assign range_o  = in_range;
  assign waddr    = AW'(in_index);
  assign raddr    = cmd_i.rd_fetch ? AW'(in_index) : cnt_r[AW-1:0];

  // The read data is held until the next store read is issued.
  always_ff @(posedge clk) begin
    if (cmd_i.load_write) begin
      sample_mem[waddr] <= in_sample;
      gain_mem[waddr]   <= in_gain;
      offset_mem[waddr] <= in_offset;
    end
    if (cmd_i.rd_fetch || issue) begin
      x_q <= sample_mem[raddr];
      g_q <= gain_mem[raddr];
      o_q <= offset_mem[raddr];
    end
  end

  // Statistics registers.
  logic signed [MeanW-1:0] mean_r;
  logic [InvW-1:0]         inv_r;
  logic signed [MeanW-1:0] mean_new_r;
  logic signed [SumW-1:0]  sum_r;
  logic [SqW-1:0]          sq_r;
  logic                    pend_r;  // store read in flight for the pass
  logic                    mean_pend_r;  // set from the mean divide to the variance divide

  assign sts_o.pass_done = (cnt_r == len_i) && !pend_r && !rvalid_r;

  assign issue = (cmd_i.sum_step || cmd_i.var_step) && (cnt_r != len_i);

  logic signed [33:0] dv;
  logic [33:0]        dabs;
  assign dv   = 34'(signed'({x_q, 8'h00})) - 34'(mean_new_r);
  assign dabs = dv[33] ? 34'(-dv) : dv;

  // Shared restoring divider, one quotient bit per cycle.
  logic [DivW-1:0] num_r, den_r, quo_r;
  logic [DivW:0]   rem_r;
  logic [DcW-1:0]  dcnt_r;
  logic            dbusy_r;
  logic [1:0]      dop_r;  // 0 mean, 1 variance, 2 reciprocal
  logic [DivW:0]   rem_sh;
  assign rem_sh = {rem_r[DivW-1:0], num_r[DivW-1]};

  // Bit-serial integer square root, one result bit per cycle.
  logic [DivW-1:0] sx_r, sr_r, sb_r;
  logic            sbusy_r;
  logic [InvW-1:0] inv_new_r;

  assign sts_o.unit_busy = dbusy_r || sbusy_r;

  logic [DivW-1:0] vsum;
  logic [DivW-1:0] nlen;
  assign nlen = DivW'(len_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rvalid_r <= 1'b0;
      pend_r   <= 1'b0;
      dbusy_r  <= 1'b0;
      sbusy_r  <= 1'b0;
      mean_r   <= '0;
      inv_r    <= InvW'(24'h010000);
    end else begin
      pend_r   <= issue;
      rvalid_r <= pend_r;
      if (cmd_i.stat_clear) begin
        cnt_r <= '0;
        sum_r <= '0;
        sq_r  <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (pend_r) begin
        if (!mean_pend_r)
          sum_r <= sum_r + SumW'(x_q);
        else
          sq_r <= sq_r + SqW'(dabs * dabs);
      end
      // Divider.
      if (cmd_i.mean_start) begin
        // mean = floor((sum*512 + n) / (2n)); a bias of 2n * 2^35 keeps the
        // dividend positive and is taken off the quotient afterwards.
        num_r  <= (DivW'(sum_r) << 9) + nlen + (nlen << 36);
        den_r  <= nlen << 1;
        rem_r  <= '0;
        dcnt_r <= DcW'(DivW);
        dbusy_r <= 1'b1;
        dop_r  <= 2'd0;
      end else if (cmd_i.var_start) begin
        num_r  <= sq_r + (nlen << 15);
        den_r  <= nlen << 16;
        rem_r  <= '0;
        dcnt_r <= DcW'(DivW);
        dbusy_r <= 1'b1;
        dop_r  <= 2'd1;
      end else if (cmd_i.recip_start) begin
        num_r  <= DivW'(1) << 48;
        den_r  <= (vsum == '0) ? DivW'(1) : vsum;
        rem_r  <= '0;
        dcnt_r <= DcW'(DivW);
        dbusy_r <= 1'b1;
        dop_r  <= 2'd2;
      end else if (dbusy_r) begin
        num_r <= num_r << 1;
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r <= rem_sh - {1'b0, den_r};
          quo_r <= {quo_r[DivW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[DivW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 1'b1;
        if (dcnt_r == DcW'(1)) dbusy_r <= 1'b0;
      end
      if (!dbusy_r && dop_r == 2'd0 && mean_pend_r)
        mean_new_r <= MeanW'(quo_r - (DivW'(1) << 35));
      // Square root.
      if (cmd_i.sqrt_start) begin
        sx_r    <= quo_r;
        sr_r    <= '0;
        sb_r    <= DivW'(1) << 62;
        sbusy_r <= 1'b1;
      end else if (sbusy_r) begin
        if (sx_r >= sr_r + sb_r) begin
          sx_r <= sx_r - (sr_r + sb_r);
          sr_r <= (sr_r >> 1) + sb_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sb_r <= sb_r >> 2;
        if (sb_r == DivW'(1)) sbusy_r <= 1'b0;
      end
      if (cmd_i.commit) begin
        mean_r <= mean_new_r;
        inv_r  <= (sr_r > DivW'(24'hFFFFFF)) ? 24'hFFFFFF : sr_r[InvW-1:0];
      end
    end
  end

  // Mode tracking: the reads of the variance pass come after the mean divide.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_pend_r <= 1'b0;
    end else begin
      if (cmd_i.mean_start) mean_pend_r <= 1'b1;
      else if (cmd_i.var_start || cmd_i.commit) mean_pend_r <= 1'b0;
    end
  end

  assign vsum = quo_r + DivW'(eps_i);

  // Variance quotient is held in quo_r until recip_start uses vsum.

  // Read pipeline.
  logic signed [33:0] rd_d_r;
  logic signed [58:0] prod1;
  logic signed [42:0] t_r;
  logic signed [58:0] prod2;
  logic signed [42:0] u_r;
  logic signed [15:0] g_r, o_r;
  logic               oob_r;
  logic signed [43:0] r_s;

  assign prod1 = rd_d_r * $signed({1'b0, inv_r});
  assign prod2 = t_r * g_r;
  assign r_s   = 44'(u_r) + 44'(o_r);

  always_ff @(posedge clk) begin
    if (cmd_i.rd_fetch) oob_r <= ~in_range;
    if (cmd_i.rd_mul1) begin
      rd_d_r <= 34'(signed'({x_q, 8'h00})) - 34'(mean_r);
      g_r <= g_q;
      o_r <= o_q;
    end
    if (cmd_i.rd_mul2) t_r <= 43'((prod1 + 59'sd32768) >>> 16);
    if (cmd_i.rd_out) u_r <= 43'((prod2 + 59'sd32768) >>> 16);
  end

  // The mul1 stage latches d, gain and offset; its product is taken next cycle.
  logic rd_fin_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_fin_r <= 1'b0;
    end else begin
      rd_fin_r <= cmd_i.rd_out;
    end
  end

  assign out_valid = rd_fin_r;
  always_comb begin
    if (oob_r) out_normalized = '0;
    else if (r_s > 44'sd32767) out_normalized = 16'sh7FFF;
    else if (r_s < -44'sd32768) out_normalized = -16'sh8000;
    else out_normalized = r_s[15:0];
  end

endmodule

// File: tb/tb_layer_normalization_unit.sv
// Self-checking testbench for layer_normalization_unit: loads rows, reads back
// normalized elements and compares them with a bit-exact fixed-point predictor.
// Depends on lnu_pkg and the layer_normalization_unit RTL.
`timescale 1ns / 1ps

// The scoreboard keeps its own copy of the element stores, the statistics and
// the two registers, and queues the value each read transfer must return.
class norm_scoreboard;
  int    errors;
  int    sample_mem[1024];
  int    gain_mem[1024];
  int    offset_mem[1024];
  longint mean_q16;
  longint inv_dev;
  int    len_reg;
  int    eps_reg;
  logic signed [15:0] expected_q[$];

  function new();
    errors   = 0;
    mean_q16 = 0;
    inv_dev  = 64'h10000;
    len_reg  = 1024;
    eps_reg  = 1;
  endfunction

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function int eff_len();
    if (len_reg < 1) return 1;
    if (len_reg > 1024) return 1024;
    return len_reg;
  endfunction

  function void write_reg(logic idx, logic [15:0] data);
    if (idx == lnu_pkg::CfgLength) len_reg = data & 16'h07FF;
    else eps_reg = data;
  endfunction

  function void refresh_stats();
    int n;
    longint total, dev;
    longint unsigned sq, div, v;
    n = eff_len();
    total = 0;
    sq = 0;
    for (int i = 0; i < n; i++) total += sample_mem[i];
    mean_q16 = floor_div(total * 512 + n, 2 * n);
    for (int i = 0; i < n; i++) begin
      dev = sample_mem[i] * 256 - mean_q16;
      if (dev < 0) dev = -dev;
      sq += dev * dev;
    end
    div = n * 65536;
    v = (sq + div / 2) / div + eps_reg;
    if (v == 0) v = 1;
    v = int_sqrt((64'd1 << 48) / v);
    inv_dev = (v > 64'hFFFFFF) ? 64'hFFFFFF : v;
  endfunction

  // Notes one accepted input transfer.
  function void note_item(logic func, logic [9:0] idx, logic signed [15:0] smp,
                          logic signed [15:0] gn, logic signed [15:0] ofs);
    longint dev, t, u, r;
    if (func == lnu_pkg::FuncLoad) begin
      sample_mem[idx] = smp;
      gain_mem[idx]   = gn;
      offset_mem[idx] = ofs;
      if (idx == eff_len() - 1) refresh_stats();
    end else begin
      dev = longint'(sample_mem[idx]) * 256 - mean_q16;
      t = (dev * inv_dev + 32768) >>> 16;
      u = (t * gain_mem[idx] + 32768) >>> 16;
      r = u + offset_mem[idx];
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      expected_q.push_back(r[15:0]);
    end
  endfunction

  // Checks one result strobe against the oldest expectation.
  function void check_result(logic signed [15:0] got);
    logic signed [15:0] want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %0d", $time, got);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got !== want) begin
      $display("%0t: normalized mismatch, expected %0d, actual %0d", $time, want, got);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_layer_normalization_unit;
  import lnu_pkg::*;

  // Far above the slowest correct run, including one full-length row.
  localparam int CycleLimit = 1_000_000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_func = FuncLoad;
  logic [9:0]         in_index = '0;
  logic signed [15:0] in_sample = '0;
  logic signed [15:0] in_gain = '0;
  logic signed [15:0] in_offset = '0;
  logic               out_valid;
  logic signed [15:0] out_normalized;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CfgLength;
  logic [15:0]        cfg_data = '0;

  norm_scoreboard sb = new();
  bit   loaded[1024];      // which store entries hold defined data
  int   cycle_count = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  bit   gaps_on = 1'b1;

  layer_normalization_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_index       (in_index),
    .in_sample      (in_sample),
    .in_gain        (in_gain),
    .in_offset      (in_offset),
    .out_valid      (out_valid),
    .out_normalized (out_normalized),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The watchdog counts cycles and fails the run if it ever hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Results cannot be held off, so every strobe is checked in its own cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_normalized);
  end

  // Drives one item and returns at the edge where the transfer happens. The
  // start line is left high so the next item can follow back to back; gaps
  // between bursts lower it.
  task automatic send_item(logic func, logic [9:0] idx, logic signed [15:0] smp,
                           logic signed [15:0] gn, logic signed [15:0] ofs);
    if (gaps_on) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    start     <= 1'b1;
    in_func   <= func;
    in_index  <= idx;
    in_sample <= smp;
    in_gain   <= gn;
    in_offset <= ofs;
    do @(posedge clk); while (busy);
    sb.note_item(func, idx, smp, gn, ofs);
    if (func == FuncLoad) loaded[idx] = 1'b1;
    items_sent++;
  endtask

  task automatic load_elem(int idx, int smp, int gn, int ofs);
    send_item(FuncLoad, idx[9:0], smp[15:0], gn[15:0], ofs[15:0]);
  endtask

  task automatic read_elem(int idx);
    send_item(FuncRead, idx[9:0], 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Waits until all reads are answered and any statistics pass has finished,
  // so a register write sees an idle unit.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // Random sample values: mostly full range, sometimes small so that the
  // variance is tiny and the inverse deviation gets large.
  function automatic int rand_val();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 15) - 8;
    return $urandom_range(0, 65535) - 32768;
  endfunction

  function automatic int rand_loaded_index();
    int idx;
    do idx = $urandom_range(0, 1023); while (!loaded[idx]);
    return idx;
  endfunction

  // True when every entry below idx is defined, so a statistics pass that
  // ends at idx touches only written data.
  function automatic bit prefix_loaded(int idx);
    for (int i = 0; i < idx; i++) if (!loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  // A stray load anywhere; a load that would start a pass over undefined
  // entries is moved to the first hole instead.
  task automatic stray_load();
    int idx;
    idx = $urandom_range(0, 1023);
    if (idx == sb.eff_len() - 1 && !prefix_loaded(idx)) begin
      idx = 0;
      while (loaded[idx]) idx++;
    end
    load_elem(idx, rand_val(), rand_val(), rand_val());
  endtask

  // One well-formed row: every element in order, the last load starting the
  // statistics, then reads of the row and of older entries. Long rows get a
  // short read phase.
  task automatic run_row();
    int n;
    n = sb.eff_len();
    for (int i = 0; i < n; i++) load_elem(i, rand_val(), rand_val(), rand_val());
    repeat ((n > 64) ? $urandom_range(8, 32) : $urandom_range(n, 2 * n + 4)) begin
      if ($urandom_range(0, 3) == 0) read_elem(rand_loaded_index());
      else read_elem($urandom_range(0, n - 1));
    end
  endtask

  initial begin
    int len, eps;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reads before any completed row use the reset statistics.
    load_elem(5, 32767, 32767, -32768);
    read_elem(5);
    load_elem(6, -32768, -32768, 32767);
    read_elem(6);
    load_elem(1000, 12345, -256, 77);
    read_elem(1000);
    settle();

    // A single element has zero variance; with epsilon zero the inverse
    // deviation saturates.
    write_cfg(CfgLength, 16'd1);
    write_cfg(CfgEpsilon, 16'd0);
    load_elem(0, -32768, -32768, 32767);
    read_elem(0);
    read_elem(5);     // beyond the row length, still a stored entry
    read_elem(1000);
    settle();

    write_cfg(CfgLength, 16'd2);
    write_cfg(CfgEpsilon, 16'hFFFF);
    load_elem(0, 32767, 32767, 32767);
    load_elem(1, -32768, 32767, -32768);
    read_elem(0);
    read_elem(1);
    read_elem(6);
    settle();

    // A length of zero behaves as one.
    write_cfg(CfgLength, 16'd0);
    load_elem(0, 256, 256, 0);
    read_elem(0);
    read_elem(1);
    settle();

    // An oversized length clamps to the full vector: one complete row.
    write_cfg(CfgLength, 16'h07FF);
    write_cfg(CfgEpsilon, 16'd1);
    gaps_on = 1'b0;
    run_row();
    settle();

    // Random phases, mostly short rows, each with its own register setting.
    while (items_sent < 1150) begin
      case ($urandom_range(0, 5))
        0: len = $urandom_range(1, 64);
        1: len = 1;
        default: len = $urandom_range(2, 16);
      endcase
      case ($urandom_range(0, 3))
        0: eps = 0;
        1: eps = 65535;
        default: eps = $urandom_range(0, 65535);
      endcase
      write_cfg(CfgLength, len[15:0]);
      write_cfg(CfgEpsilon, eps[15:0]);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        run_row();
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 1) == 0) stray_load();
          else read_elem(rand_loaded_index());
        end
      end
      settle();
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
